FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

FILE: hw/rtl/mst_pkg.sv
// ---------------------------------------------------------------------------
// mst_pkg
// Shared constants, words and codes of the min tracking stack.
// ---------------------------------------------------------------------------
package mst_pkg;

  localparam int unsigned DataWidth  = 32;
  localparam int unsigned Depth      = 1024;
  localparam int unsigned EntryWidth = DataWidth + 1;
  localparam int unsigned AddrWidth  = $clog2(Depth);
  localparam int unsigned FillWidth  = $clog2(Depth + 1);

  // Minimum register after reset: largest positive value.
  localparam logic signed [DataWidth-1:0] MinReset = {1'b0, {(DataWidth-1){1'b1}}};

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_QUERY = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_WAIT
  } state_e;

  typedef struct packed {
    logic        [1:0]           mode;
    logic signed [DataWidth-1:0] data_in;
  } in_word_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] value_out;
    logic signed [DataWidth-1:0] minimum_out;
    logic                        empty_flag;
    logic        [1:0]           status;
  } out_word_t;

  // State update produced by one operation.
  typedef struct packed {
    logic                        wr_en;
    logic [AddrWidth-1:0]        wr_addr;
    logic [EntryWidth-1:0]       wr_data;
    logic [FillWidth-1:0]        fill;
    logic signed [DataWidth-1:0] minimum;
  } upd_t;

endpackage

FILE: hw/rtl/mst_ram.sv
// ---------------------------------------------------------------------------
// mst_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module mst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/mst_step.sv
// ---------------------------------------------------------------------------
// mst_step
// Operation datapath: offset encode on push, decode on pop and query.
// ---------------------------------------------------------------------------
module mst_step (
  input  logic [1:0]                                 mode_i,
  input  logic signed [mst_pkg::DataWidth-1:0]       data_i,
  input  logic [mst_pkg::EntryWidth-1:0]             rd_data_i,
  input  logic [mst_pkg::FillWidth-1:0]              fill_i,
  input  logic signed [mst_pkg::DataWidth-1:0]       min_i,
  output mst_pkg::upd_t                              upd_o,
  output mst_pkg::out_word_t                         res_o
);

  localparam int unsigned DW = mst_pkg::DataWidth;
  localparam int unsigned EW = mst_pkg::EntryWidth;
  localparam int unsigned FW = mst_pkg::FillWidth;
  localparam int unsigned AW = mst_pkg::AddrWidth;

  logic signed [EW-1:0] data_x;
  logic signed [EW-1:0] min_x;
  logic signed [EW-1:0] off;
  logic signed [EW-1:0] prev_min;
  logic                 full;
  logic                 empty;
  logic                 off_neg;
  logic [FW-1:0]        fill_new;
  logic signed [DW-1:0] min_new;

  assign data_x   = {data_i[DW-1], data_i};
  assign min_x    = {min_i[DW-1], min_i};
  assign off      = rd_data_i;
  assign off_neg  = off[EW-1];
  assign prev_min = min_x - off;
  assign full     = (fill_i == FW'(mst_pkg::Depth));
  assign empty    = (fill_i == '0);

  always_comb begin
    upd_o.wr_en   = 1'b0;
    upd_o.wr_addr = fill_i[AW-1:0];
    upd_o.wr_data = data_x - min_x;
    fill_new      = fill_i;
    min_new       = min_i;
    res_o.value_out = data_i;
    res_o.status    = mst_pkg::STAT_OK;

    if (mode_i == mst_pkg::MODE_PUSH) begin
      if (full) begin
        res_o.status = mst_pkg::STAT_FULL;
      end else begin
        upd_o.wr_en = 1'b1;
        fill_new    = fill_i + FW'(1);
        if (empty) begin
          upd_o.wr_data = '0;
          min_new       = data_i;
        end else if (data_i < min_i) begin
          min_new = data_i;
        end
      end
    end else if (empty) begin
      res_o.value_out = '1;
      res_o.status    = mst_pkg::STAT_EMPTY;
    end else begin
      // negative offset: this entry lowered the minimum
      res_o.value_out = off_neg ? min_i : (min_i + off[DW-1:0]);
      if (mode_i == mst_pkg::MODE_POP) begin
        fill_new = fill_i - FW'(1);
        if (off_neg) begin
          min_new = prev_min[DW-1:0];
        end
      end
    end

    upd_o.fill        = fill_new;
    upd_o.minimum     = min_new;
    res_o.empty_flag  = (fill_new == '0);
    res_o.minimum_out = (fill_new == '0) ? '1 : min_new;
  end

endmodule

FILE: hw/rtl/min_tracking_stack.sv
// ---------------------------------------------------------------------------
// min_tracking_stack
// LIFO stack of signed words that reports its running minimum.
// ---------------------------------------------------------------------------
// Each input word is a push, a pop or a query (mode three acts as a query);
// each yields exactly one result word with the value, the minimum after the
// operation, an empty flag and a status. Entries live in a 1024 x 33 RAM as
// offsets from the minimum in force before their push; a negative offset marks
// an entry that lowered the minimum and carries the way back on pop. A push,
// or a pop or query on an empty stack, is computed in idle; a pop or query on a
// non-empty stack goes through the read state, as the top entry comes from
// the RAM's registered read port. The RAM needs no clearing after reset: only
// entries below the fill count are ever read. An output register decouples
// the sides, so one more word is accepted while a result waits on out_stall_i.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module min_tracking_stack (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mst_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mst_pkg::out_word_t out_word_o
);

  localparam int unsigned FW = mst_pkg::FillWidth;
  localparam int unsigned AW = mst_pkg::AddrWidth;
  localparam int unsigned EW = mst_pkg::EntryWidth;

  mst_pkg::state_e state_q, state_d;

  logic [FW-1:0]                        fill_q;
  logic signed [mst_pkg::DataWidth-1:0] min_q;
  logic [1:0]                           op_q;

  mst_pkg::out_word_t out_q, out_d, pend_q, step_res;
  logic               out_valid_q, out_valid_d;
  mst_pkg::upd_t      upd;

  logic          in_acc;
  logic          needs_read;
  logic          slot_free;
  logic          commit;
  logic          load_out;
  logic          load_pend;
  logic          use_pend;
  logic          ram_we;
  logic [EW-1:0] rd_data;
  logic [1:0]    step_mode;

  // Handshake: one operation in flight; take a word only in idle.
  assign in_stall_o = (state_q != mst_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;

  // Pop or query on a non-empty stack must fetch the top entry first.
  assign needs_read = (in_word_i.mode != mst_pkg::MODE_PUSH) && (fill_q != '0);

  assign step_mode = (state_q == mst_pkg::ST_RD) ? op_q : in_word_i.mode;

  mst_step u_step (
    .mode_i    (step_mode),
    .data_i    (in_word_i.data_in),
    .rd_data_i (rd_data),
    .fill_i    (fill_q),
    .min_i     (min_q),
    .upd_o     (upd),
    .res_o     (step_res)
  );

  // Writes only happen on push in idle and reads are issued at accept,
  // so a read never meets a write to the same entry in the same cycle.
  assign ram_we = commit && upd.wr_en;

  mst_ram #(
    .Width (EW),
    .Depth (mst_pkg::Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (upd.wr_addr),
    .wdata_i (upd.wr_data),
    .re_i    (in_acc && needs_read),
    .raddr_i (AW'(fill_q - FW'(1))),
    .rdata_o (rd_data)
  );

  // Control: next state plus commit and output-load strobes.
  always_comb begin
    state_d   = state_q;
    commit    = 1'b0;
    load_out  = 1'b0;
    load_pend = 1'b0;
    use_pend  = 1'b0;
    case (state_q)
      mst_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (needs_read) begin
            state_d = mst_pkg::ST_RD;
          end else begin
            commit = 1'b1;
            if (slot_free) begin
              load_out = 1'b1;
            end else begin
              load_pend = 1'b1;
              state_d   = mst_pkg::ST_WAIT;
            end
          end
        end
      end
      mst_pkg::ST_RD: begin
        commit = 1'b1;
        if (slot_free) begin
          load_out = 1'b1;
          state_d  = mst_pkg::ST_IDLE;
        end else begin
          load_pend = 1'b1;
          state_d   = mst_pkg::ST_WAIT;
        end
      end
      mst_pkg::ST_WAIT: begin
        // result parked until the output register drains
        if (slot_free) begin
          load_out = 1'b1;
          use_pend = 1'b1;
          state_d  = mst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mst_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_d       = use_pend ? pend_q : step_res;
  assign out_valid_d = load_out ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mst_pkg::ST_IDLE;
      fill_q      <= '0;
      min_q       <= mst_pkg::MinReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        fill_q <= upd.fill;
        min_q  <= upd.minimum;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= in_word_i.mode;
    end
    if (load_pend) begin
      pend_q <= step_res;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Assertions
  `ASSERT_PROP(a_fill_range, clk_i, rst_ni, fill_q <= FW'(mst_pkg::Depth), "fill count past depth")
  `ASSERT_PROP(a_rd_after_acc, clk_i, rst_ni, (state_q == mst_pkg::ST_RD) |-> $past(in_acc), "read state without accept")
  `ASSERT_PROP(a_wait_holds_out, clk_i, rst_ni, (state_q == mst_pkg::ST_WAIT) |-> out_valid_q, "parked result with empty output")
  `ASSERT_NEVER(a_no_wr_in_rd, clk_i, rst_ni, ram_we && (state_q != mst_pkg::ST_IDLE), "RAM write outside idle")

endmodule

FILE: dv/min_tracking_stack_tb.sv
// ---------------------------------------------------------------------------
// min_tracking_stack_tb
// Self-checking bench for the min tracking stack.
// ---------------------------------------------------------------------------
// A shadow stack in the bench keeps its own offsets, fill count and minimum.
// It predicts every result word as each input word is accepted. A short
// directed table covers the empty stack, the extreme values, every mode and
// the ways a push can move the minimum. Random words follow. They walk the
// depth up and down, and one burst fills the stack to the top so that pushes
// are dropped. Both sides idle and stall at random, with one stretch where
// they never do.
// ---------------------------------------------------------------------------
module min_tracking_stack_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mst_pkg::*;

  localparam time         ClkPeriod     = 20ns;
  localparam int unsigned ResetCycles   = 7;
  localparam int unsigned RandomWords   = 600;
  // Any quiet stretch in a correct run is a chain of random idle or stall
  // cycles at 26 percent each, so one as long as the limit never happens.
  localparam int unsigned WatchdogLimit = 2000;
  // Pop and query on a non-empty stack pass the read state, plus the output register.
  localparam int unsigned DrainCycles   = 16;

  // The spare mode code is decoded as a query.
  localparam logic [1:0]                  ModeSpare = 2'd3;
  localparam logic signed [DataWidth-1:0] DataMin   = {1'b1, {(DataWidth-1){1'b0}}};
  localparam logic signed [DataWidth-1:0] NoValue   = '1;

  typedef logic signed [EntryWidth-1:0] offset_t;

  typedef struct {
    in_word_t  word;
    bit        fixed;   // result typed into the table, not predicted
    out_word_t result;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  // Travels next to in_word_i: a typed result for directed rows.
  bit        row_fixed  = 1'b0;
  out_word_t row_result = '0;

  int unsigned idle_pct  = 26;
  int unsigned stall_pct = 26;

  // Shadow of the stack.
  offset_t                     shadow_entries [Depth];
  int unsigned                 shadow_fill = 0;
  logic signed [DataWidth-1:0] shadow_min  = MinReset;

  out_word_t results_due [$];
  dir_row_t  directed_rows [$];

  int unsigned err_count   = 0;
  int unsigned quiet_count = 0;
  int unsigned n_push = 0, n_pop = 0, n_query = 0;
  int unsigned n_lowered = 0, n_dropped = 0, n_on_empty = 0, peak_fill = 0;

  min_tracking_stack dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // -------------------------------------------------------------------------
  // Shadow stack: apply one word, return the result word it must produce.
  // Entries hold the pushed value minus the minimum before that push, one bit
  // wider than the data; a negative entry lowered the minimum and its
  // magnitude leads back to the previous one on pop.
  // -------------------------------------------------------------------------
  function automatic out_word_t predict_stack_op(input in_word_t w);
    out_word_t r;
    offset_t   off;
    r.value_out = w.data_in;
    r.status    = STAT_OK;
    if (w.mode == MODE_PUSH) begin
      n_push++;
      if (shadow_fill == Depth) begin
        r.status = STAT_FULL;
        n_dropped++;
      end else begin
        if (shadow_fill == 0) begin
          shadow_entries[0] = '0;
          shadow_min        = w.data_in;
        end else begin
          off = $signed({w.data_in[DataWidth-1], w.data_in})
              - $signed({shadow_min[DataWidth-1], shadow_min});
          shadow_entries[shadow_fill] = off;
          if (off < 0) begin
            shadow_min = w.data_in;
            n_lowered++;
          end
        end
        shadow_fill++;
        if (shadow_fill > peak_fill) peak_fill = shadow_fill;
      end
    end else begin
      if (w.mode == MODE_POP) n_pop++;
      else n_query++;
      if (shadow_fill == 0) begin
        r.value_out = NoValue;
        r.status    = STAT_EMPTY;
        n_on_empty++;
      end else begin
        off = shadow_entries[shadow_fill-1];
        // modulo arithmetic on the low data bits is exact here
        r.value_out = (off < 0) ? shadow_min : shadow_min + off[DataWidth-1:0];
        if (w.mode == MODE_POP) begin
          shadow_fill--;
          if (off < 0) shadow_min = shadow_min - off[DataWidth-1:0];
        end
      end
    end
    r.empty_flag  = (shadow_fill == 0);
    r.minimum_out = r.empty_flag ? NoValue : shadow_min;
    return r;
  endfunction

  // Data mix: extremes, neighbors of the minimum (equal, just below, just
  // above), a narrow band that repeats values, and full-range noise.
  function automatic logic signed [DataWidth-1:0] pick_data();
    case ($urandom_range(9))
      0:       return MinReset;
      1:       return DataMin;
      2:       return shadow_min;
      3:       return shadow_min - 1;
      4:       return shadow_min + 1;
      5, 6:    return $urandom_range(16) - 8;
      default: return $urandom();
    endcase
  endfunction

  // Push leans ahead of pop so the depth drifts upward; shallow stacks get
  // an extra push bias so pop on empty stays a minority.
  function automatic in_word_t pick_word();
    in_word_t    w;
    int unsigned r;
    r         = $urandom_range(99);
    w.data_in = pick_data();
    if (r < ((shadow_fill < 3) ? 60 : 46)) w.mode = MODE_PUSH;
    else if (r < 84)                       w.mode = MODE_POP;
    else if (r < 95)                       w.mode = MODE_QUERY;
    else                                   w.mode = ModeSpare;
    return w;
  endfunction

  task automatic table_row(input logic [1:0] mode, input logic signed [DataWidth-1:0] data,
                           input bit fixed, input logic signed [DataWidth-1:0] val,
                           input logic signed [DataWidth-1:0] minv, input logic emp,
                           input status_e st);
    dir_row_t row;
    row.word.mode           = mode;
    row.word.data_in        = data;
    row.fixed               = fixed;
    row.result.value_out    = val;
    row.result.minimum_out  = minv;
    row.result.empty_flag   = emp;
    row.result.status       = st;
    directed_rows.push_back(row);
  endtask

  // Present one word after a random gap and hold it until accepted. Called
  // and returns at a falling edge; valid is left high so the next call can
  // keep it high without a second assignment in the same step.
  task automatic send_word(input in_word_t w, input bit fixed, input out_word_t res);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    row_fixed  <= fixed;
    row_result <= res;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input logic [DataWidth-1:0] got,
                                 input logic [DataWidth-1:0] want);
    err_count++;
    if (err_count <= 40)
      $display("MISMATCH @%0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  // Receiver stalls at random, decided at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // -------------------------------------------------------------------------
  // Accepted input words feed the shadow stack first; accepted result words
  // are then checked against the oldest expectation. The output is
  // registered, so a result never belongs to a word taken at the same edge.
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    out_word_t want;
    bit        moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        want = predict_stack_op(in_word_i);
        if (row_fixed) want = row_result;
        results_due.push_back(want);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (results_due.size() == 0) begin
          report_mismatch("result word with nothing pending", out_word_o.value_out, '0);
        end else begin
          want = results_due.pop_front();
          if (out_word_o.value_out !== want.value_out)
            report_mismatch("value_out", out_word_o.value_out, want.value_out);
          if (out_word_o.minimum_out !== want.minimum_out)
            report_mismatch("minimum_out", out_word_o.minimum_out, want.minimum_out);
          if (out_word_o.empty_flag !== want.empty_flag)
            report_mismatch("empty_flag", out_word_o.empty_flag, want.empty_flag);
          if (out_word_o.status !== want.status)
            report_mismatch("status", out_word_o.status, want.status);
        end
      end
      // watchdog: a stretch with no word moving on either side means a hang
      quiet_count = moved ? 0 : quiet_count + 1;
      if (quiet_count >= WatchdogLimit) begin
        $display("TIMEOUT: no word moved for %0d cycles, %0d results pending",
                 WatchdogLimit, results_due.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stimulus
    in_word_t    w;
    int unsigned k;

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table. Fixed rows carry the answer by hand; the rest are
    // predicted. Data on pop and query rows is junk the block must ignore.
    table_row(MODE_POP,   NoValue,  1, NoValue,  NoValue,  1'b1, STAT_EMPTY);
    table_row(MODE_QUERY, DataMin,  1, NoValue,  NoValue,  1'b1, STAT_EMPTY);
    table_row(ModeSpare,  MinReset, 1, NoValue,  NoValue,  1'b1, STAT_EMPTY);
    // push onto empty just sets the minimum
    table_row(MODE_PUSH,  MinReset, 1, MinReset, MinReset, 1'b0, STAT_OK);
    table_row(MODE_QUERY, '0,       1, MinReset, MinReset, 1'b0, STAT_OK);
    // largest possible drop of the minimum, then the largest plain offset
    table_row(MODE_PUSH,  DataMin,  1, DataMin,  DataMin,  1'b0, STAT_OK);
    table_row(MODE_PUSH,  MinReset, 0, '0, '0, 1'b0, STAT_OK);
    table_row(MODE_QUERY, '0,       0, '0, '0, 1'b0, STAT_OK);
    table_row(MODE_POP,   NoValue,  0, '0, '0, 1'b0, STAT_OK);
    table_row(MODE_POP,   DataMin,  0, '0, '0, 1'b0, STAT_OK);
    // last entry leaves: minimum reads -1 on the now empty stack
    table_row(MODE_POP,   '0,       1, MinReset, NoValue,  1'b1, STAT_OK);
    table_row(MODE_POP,   '0,       1, NoValue,  NoValue,  1'b1, STAT_EMPTY);
    table_row(MODE_PUSH,  32'sd5,   1, 32'sd5,   32'sd5,   1'b0, STAT_OK);
    // equal to the minimum, above it, below it, equal to the new one
    table_row(MODE_PUSH,  32'sd5,   0, '0, '0, 1'b0, STAT_OK);
    table_row(MODE_PUSH,  32'sd9,   0, '0, '0, 1'b0, STAT_OK);
    table_row(MODE_PUSH,  -32'sd3,  0, '0, '0, 1'b0, STAT_OK);
    table_row(MODE_PUSH,  -32'sd3,  0, '0, '0, 1'b0, STAT_OK);
    table_row(ModeSpare,  NoValue,  0, '0, '0, 1'b0, STAT_OK);
    table_row(MODE_PUSH,  DataMin,  0, '0, '0, 1'b0, STAT_OK);
    for (k = 0; k < 6; k++) table_row(MODE_POP, $urandom(), 0, '0, '0, 1'b0, STAT_OK);

    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].fixed, directed_rows[i].result);

    // Random walk over depth with both sides noisy, then a clean stretch,
    // then a full drain before the rest.
    for (k = 0; k < RandomWords; k++) begin
      if (k == 200) begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      if (k == 360) begin
        idle_pct  = 26;
        stall_pct = 26;
        // hold off until every pending result is out
        in_valid_i <= 1'b0;
        do @(negedge clk_i); while (results_due.size() != 0);
      end
      send_word(pick_word(), 1'b0, '0);
    end

    // Fill to the top, then mix near the top, where pushes can meet the full
    // stack, and back off some.
    while (shadow_fill < Depth) begin
      w.mode    = MODE_PUSH;
      w.data_in = pick_data();
      send_word(w, 1'b0, '0);
    end
    for (k = 0; k < 40; k++) send_word(pick_word(), 1'b0, '0);
    for (k = 0; k < 40; k++) begin
      w.mode    = MODE_POP;
      w.data_in = $urandom();
      send_word(w, 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Run: %0d pushes (%0d lowered the minimum, %0d dropped when full), %0d pops,",
             n_push, n_lowered, n_dropped, n_pop);
    $display("     %0d queries, %0d pops or queries on an empty stack, peak depth %0d of %0d",
             n_query, n_on_empty, peak_fill, Depth);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/mst_pkg.sv
hw/rtl/mst_ram.sv
hw/rtl/mst_step.sv
hw/rtl/min_tracking_stack.sv
dv/min_tracking_stack_tb.sv
